### sv/afpe_pkg.sv
`default_nettype none
package afpe_pkg;

   // q30 fixed point
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;
   localparam logic [31:0] PI_Q30  = 32'd3373259426;

   // nested series: three register stages per step
   localparam int STEP_STAGES = 3;
   localparam int SIN_STEPS   = 5;
   localparam int COS_STEPS   = 6;
   localparam int TRIG_LAT    = STEP_STAGES * COS_STEPS;

   localparam logic [63:0] RECIP_ONE = 64'h1_0000_0000;

   localparam logic [31:0] SIN_K [SIN_STEPS] = '{32'd110, 32'd72, 32'd42, 32'd20, 32'd6};
   localparam logic [31:0] COS_K [COS_STEPS] =
      '{32'd132, 32'd90, 32'd56, 32'd30, 32'd12, 32'd2};

   // floor(2^32 / k) for each term constant
   localparam logic [31:0] SIN_M [SIN_STEPS] = '{
      32'(RECIP_ONE / 64'd110), 32'(RECIP_ONE / 64'd72), 32'(RECIP_ONE / 64'd42),
      32'(RECIP_ONE / 64'd20), 32'(RECIP_ONE / 64'd6)};
   localparam logic [31:0] COS_M [COS_STEPS] = '{
      32'(RECIP_ONE / 64'd132), 32'(RECIP_ONE / 64'd90), 32'(RECIP_ONE / 64'd56),
      32'(RECIP_ONE / 64'd30), 32'(RECIP_ONE / 64'd12), 32'(RECIP_ONE / 64'd2)};

endpackage
`default_nettype wire

### sv/afpe_trig.sv
`default_nettype none
module afpe_trig (
   input  logic               clock,
   input  logic [31:0]        t2_i,
   input  logic [30:0]        tmag_i,
   output logic signed [31:0] sin_o,
   output logic signed [31:0] cos_o,
   output logic [30:0]        tmag_o
);
   import afpe_pkg::*;

   localparam int T2_TAPS = STEP_STAGES * (COS_STEPS - 1);
   localparam int SIN_PAD = STEP_STAGES * (COS_STEPS - SIN_STEPS);

   logic [31:0]        t2_dly_ff   [T2_TAPS];
   logic [30:0]        tmag_dly_ff [TRIG_LAT];
   logic signed [31:0] sin_dly_ff  [SIN_PAD];

   logic [31:0]        cp_ff  [COS_STEPS];
   logic [31:0]        cpb_ff [COS_STEPS];
   logic [31:0]        cq_ff  [COS_STEPS];
   logic signed [31:0] cv_ff  [COS_STEPS];
   logic [31:0]        sp_ff  [SIN_STEPS];
   logic [31:0]        spb_ff [SIN_STEPS];
   logic [31:0]        sq_ff  [SIN_STEPS];
   logic signed [31:0] sv_ff  [SIN_STEPS];

   logic [31:0] t2_tap  [COS_STEPS];
   logic [30:0] cv_tap  [COS_STEPS];
   logic [30:0] sv_tap  [SIN_STEPS];
   logic [61:0] cprod_a [COS_STEPS];
   logic [63:0] cprod_b [COS_STEPS];
   logic [31:0] crem    [COS_STEPS];
   logic [61:0] sprod_a [SIN_STEPS];
   logic [63:0] sprod_b [SIN_STEPS];
   logic [31:0] srem    [SIN_STEPS];

   always_comb begin
      t2_tap[0] = t2_i;
      cv_tap[0] = Q30_ONE;
      sv_tap[0] = Q30_ONE;
      for (int g = 1; g < COS_STEPS; g++) begin
         t2_tap[g] = t2_dly_ff[STEP_STAGES * g - 1];
         cv_tap[g] = cv_ff[g - 1][30:0];
      end
      for (int g = 1; g < SIN_STEPS; g++) begin
         sv_tap[g] = sv_ff[g - 1][30:0];
      end
      for (int g = 0; g < COS_STEPS; g++) begin
         cprod_a[g] = 62'(t2_tap[g]) * 62'(cv_tap[g]);
         cprod_b[g] = 64'(cp_ff[g]) * 64'(COS_M[g]);
         crem[g]    = cpb_ff[g] - cq_ff[g] * COS_K[g];
      end
      for (int g = 0; g < SIN_STEPS; g++) begin
         sprod_a[g] = 62'(t2_tap[g]) * 62'(sv_tap[g]);
         sprod_b[g] = 64'(sp_ff[g]) * 64'(SIN_M[g]);
         srem[g]    = spb_ff[g] - sq_ff[g] * SIN_K[g];
      end
   end

   // per step: product, reciprocal quotient, quotient fix-up and subtract
   always_ff @(posedge clock) begin
      t2_dly_ff[0]   <= t2_i;
      tmag_dly_ff[0] <= tmag_i;
      for (int i = 1; i < T2_TAPS; i++) t2_dly_ff[i] <= t2_dly_ff[i - 1];
      for (int i = 1; i < TRIG_LAT; i++) tmag_dly_ff[i] <= tmag_dly_ff[i - 1];
      for (int g = 0; g < COS_STEPS; g++) begin
         cp_ff[g]  <= cprod_a[g][61:30];
         cpb_ff[g] <= cp_ff[g];
         cq_ff[g]  <= cprod_b[g][63:32];
         cv_ff[g]  <= $signed({1'b0, Q30_ONE} - cq_ff[g]
                              - {31'b0, (crem[g] >= COS_K[g])});
      end
      for (int g = 0; g < SIN_STEPS; g++) begin
         sp_ff[g]  <= sprod_a[g][61:30];
         spb_ff[g] <= sp_ff[g];
         sq_ff[g]  <= sprod_b[g][63:32];
         sv_ff[g]  <= $signed({1'b0, Q30_ONE} - sq_ff[g]
                              - {31'b0, (srem[g] >= SIN_K[g])});
      end
      sin_dly_ff[0] <= sv_ff[SIN_STEPS - 1];
      for (int i = 1; i < SIN_PAD; i++) sin_dly_ff[i] <= sin_dly_ff[i - 1];
   end

   assign sin_o  = sin_dly_ff[SIN_PAD - 1];
   assign cos_o  = cv_ff[COS_STEPS - 1];
   assign tmag_o = tmag_dly_ff[TRIG_LAT - 1];

endmodule
`default_nettype wire

### sv/axial_field_profile_eval.sv
`default_nettype none
// channel   direction  handshake                  payload
// req       in         start high, busy low       req_x_pos, req_y_pos, req_z_pos
// rsp       out        rsp_valid, one cycle       rsp_b_x, rsp_b_y, rsp_b_z, rsp_e_z
// csr       in         csr_valid and csr_ready    csr_index, csr_wdata
//
// one item is taken every cycle while busy is low
// the core of the pipeline is the sine and cosine series (six steps of three stages each)
// busy and not-ready only while reset is high; synchronous reset clears valid bits
// the receiver cannot stall, so the pipeline never holds and nothing is repeated
module axial_field_profile_eval (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [18:0] req_x_pos,
   input  logic signed [18:0] req_y_pos,
   input  logic signed [18:0] req_z_pos,
   output logic               rsp_valid,
   output logic signed [23:0] rsp_b_x,
   output logic signed [23:0] rsp_b_y,
   output logic signed [23:0] rsp_b_z,
   output logic signed [15:0] rsp_e_z,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import afpe_pkg::*;

   // register indexes
   localparam logic [1:0] CSR_EZ_CENTER = 2'd0;
   localparam logic [1:0] CSR_EZ_GAP    = 2'd1;

   // knots bounding the two shaped segments, in 1/16 mm
   localparam logic signed [18:0] Z_K1 = -19'sd35200;
   localparam logic signed [18:0] Z_K2 = -19'sd24000;
   localparam logic signed [18:0] Z_K3 = 19'sd24000;
   localparam logic signed [18:0] Z_K4 = 19'sd35200;
   // segment start plus half its length
   localparam logic signed [19:0] Z_MID = 20'sd29600;

   // divisors and their reciprocals
   localparam logic [63:0] D_T  = 64'd11200;
   localparam logic [63:0] D_B  = 64'd875;
   localparam logic [63:0] D_BZ = 64'd10;
   localparam logic [18:0] M_T  = 19'(RECIP_ONE / D_T);
   localparam logic [22:0] M_B  = 23'(RECIP_ONE / D_B);
   localparam logic [28:0] M_BZ = 29'(RECIP_ONE / D_BZ);
   localparam logic [18:0] T_A  = 19'({32'b0, PI_Q30} / D_T);
   localparam logic [13:0] T_R  = 14'({32'b0, PI_Q30} % D_T);
   localparam logic [34:0] BZ_HALF = 35'd81920;
   localparam logic [51:0] BX_HALF = 52'd1835008000;

   localparam int PRE      = 5;
   localparam int IX_P1    = PRE + TRIG_LAT;
   localparam int SIDE_LEN = IX_P1 + 4;

   typedef enum logic [1:0] {BASE_6, BASE_8, BASE_10} base_type;
   typedef enum logic [1:0] {EZ_CENTER, EZ_GAP, EZ_ZERO} ez_type;

   typedef struct packed {
      logic        amp_zero;
      logic        amp_neg;
      logic        m_neg;
      base_type    base;
      ez_type      ez;
      logic        x_neg;
      logic        y_neg;
      logic [18:0] x_mag;
      logic [18:0] y_mag;
   } side_type;

   logic signed [15:0] ez_center_ff, ez_gap_ff;
   logic [SIDE_LEN-1:0] valid_ff;
   side_type side_ff [SIDE_LEN];
   side_type side_in;

   // front end: segment choice and angle
   logic               seg1, seg2, seg3;
   logic signed [19:0] m_wide;
   logic [12:0]        m_mag_in, m_mag1_ff;
   logic [30:0]        pa2_ff, pa3_ff;
   logic [25:0]        pr2_ff, pr3_ff;
   logic [44:0]        t_prod;
   logic [12:0]        q3_ff;
   logic [25:0]        t_rem;
   logic [30:0]        tmag4_ff, tmag5_ff;
   logic [61:0]        t_sq;
   logic [31:0]        t2_5_ff;

   logic signed [31:0] sin_t, cos_t;
   logic [30:0]        tmag_t;

   // back end
   logic [61:0] s_prod;
   logic [62:0] k_prod;
   logic [30:0] c_mag;
   logic [30:0] sq1_ff;
   logic [31:0] kq1_ff;
   logic [3:0]  cneg_ff;
   logic [50:0] nx2_ff, ny2_ff;
   logic [34:0] base_w, sq2_w, v_w;
   logic [20:0] u2_ff, u3_ff;
   logic [29:0] wx3_ff, wy3_ff, wx4_ff, wy4_ff;
   logic [49:0] bz_prod;
   logic [17:0] bq3_ff, bz4_ff;
   logic [20:0] bz_rem;
   logic [52:0] bx_prod, by_prod;
   logic [20:0] qx4_ff, qy4_ff, qx, qy;
   logic [29:0] rx, ry;
   logic        bx_neg, by_neg;

   logic               rsp_valid_ff;
   logic signed [23:0] rsp_b_x_ff, rsp_b_y_ff, rsp_b_z_ff;
   logic signed [15:0] rsp_e_z_ff;

   assign busy      = reset;
   assign csr_ready = ~reset;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ez_center_ff <= 16'sd410;
         ez_gap_ff    <= 16'sd1755;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EZ_CENTER: ez_center_ff <= $signed(csr_wdata);
            CSR_EZ_GAP:    ez_gap_ff    <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // segment of z: 1 and 3 carry the cosine shape, the rest are flat
   always_comb begin
      seg1 = (req_z_pos >= Z_K1) && (req_z_pos < Z_K2);
      seg2 = (req_z_pos >= Z_K2) && (req_z_pos < Z_K3);
      seg3 = (req_z_pos >= Z_K3) && (req_z_pos < Z_K4);
      if (seg1) begin
         m_wide = $signed({req_z_pos[18], req_z_pos}) + Z_MID;
      end else if (seg3) begin
         m_wide = $signed({req_z_pos[18], req_z_pos}) - Z_MID;
      end else begin
         m_wide = 20'sd0;
      end
      m_mag_in = m_wide[19] ? 13'(-m_wide) : 13'(m_wide);

      side_in.amp_zero = !(seg1 || seg3);
      side_in.amp_neg  = seg1;
      side_in.m_neg    = m_wide[19];
      if (seg2) begin
         side_in.base = BASE_10;
      end else if (seg1 || seg3) begin
         side_in.base = BASE_8;
      end else begin
         side_in.base = BASE_6;
      end
      if ((req_z_pos >= Z_K2) && (req_z_pos <= Z_K3)) begin
         side_in.ez = EZ_CENTER;
      end else if ((req_z_pos > Z_K3) && (req_z_pos < Z_K4)) begin
         side_in.ez = EZ_GAP;
      end else begin
         side_in.ez = EZ_ZERO;
      end
      side_in.x_neg = req_x_pos[18];
      side_in.y_neg = req_y_pos[18];
      side_in.x_mag = req_x_pos[18] ? (~req_x_pos + 19'd1) : req_x_pos;
      side_in.y_mag = req_y_pos[18] ? (~req_y_pos + 19'd1) : req_y_pos;
   end

   // valid bits and side data travel with the item
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= {valid_ff[SIDE_LEN-2:0], start && !busy};
         rsp_valid_ff <= valid_ff[SIDE_LEN-1];
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int i = 1; i < SIDE_LEN; i++) side_ff[i] <= side_ff[i - 1];
   end

   // |t| = pi_q30 * |m| / 11200, split as |m|*A + |m|*R/11200
   assign t_prod = 45'(pr2_ff) * 45'(M_T);
   assign t_rem  = pr3_ff - 26'(q3_ff) * 26'(D_T);
   assign t_sq   = 62'(tmag4_ff) * 62'(tmag4_ff);

   always_ff @(posedge clock) begin
      m_mag1_ff <= m_mag_in;
      pa2_ff    <= 31'(m_mag1_ff) * 31'(T_A);
      pr2_ff    <= 26'(m_mag1_ff) * 26'(T_R);
      q3_ff     <= t_prod[44:32];
      pa3_ff    <= pa2_ff;
      pr3_ff    <= pr2_ff;
      tmag4_ff  <= pa3_ff + 31'(q3_ff) + 31'(t_rem >= 26'(D_T));
      tmag5_ff  <= tmag4_ff;
      t2_5_ff   <= t_sq[61:30];
   end

   afpe_trig u_trig (
      .clock  (clock),
      .t2_i   (t2_5_ff),
      .tmag_i (tmag5_ff),
      .sin_o  (sin_t),
      .cos_o  (cos_t),
      .tmag_o (tmag_t)
   );

   // sine scaled by |t|, cosine scaled by pi
   assign s_prod = 62'(tmag_t) * 62'(sin_t[30:0]);
   assign c_mag  = cos_t[31] ? 31'(-cos_t) : 31'(cos_t);
   assign k_prod = 63'(PI_Q30) * 63'(c_mag);

   // axial field: base minus amp times signed sine, rounded
   always_comb begin
      case (side_ff[IX_P1].base)
         BASE_6:  base_w = 35'd6 << 30;
         BASE_8:  base_w = 35'd8 << 30;
         BASE_10: base_w = 35'd10 << 30;
         default: base_w = 35'd6 << 30;
      endcase
      sq2_w = side_ff[IX_P1].amp_zero ? 35'd0 : {3'b0, sq1_ff, 1'b0};
      if (side_ff[IX_P1].amp_neg == side_ff[IX_P1].m_neg) begin
         v_w = base_w - sq2_w;
      end else begin
         v_w = base_w + sq2_w;
      end
   end

   assign bz_prod = 50'(u2_ff) * 50'(M_BZ);
   assign bz_rem  = u3_ff - 21'(bq3_ff) * 21'(D_BZ);
   assign bx_prod = 53'(wx3_ff) * 53'(M_B);
   assign by_prod = 53'(wy3_ff) * 53'(M_B);
   assign rx      = wx4_ff - 30'(qx4_ff) * 30'(D_B);
   assign ry      = wy4_ff - 30'(qy4_ff) * 30'(D_B);
   assign qx      = qx4_ff + 21'(rx >= 30'(D_B));
   assign qy      = qy4_ff + 21'(ry >= 30'(D_B));
   assign bx_neg  = side_ff[SIDE_LEN-1].amp_neg ^ cneg_ff[3] ^ side_ff[SIDE_LEN-1].x_neg;
   assign by_neg  = side_ff[SIDE_LEN-1].amp_neg ^ cneg_ff[3] ^ side_ff[SIDE_LEN-1].y_neg;

   always_ff @(posedge clock) begin
      sq1_ff  <= s_prod[60:30];
      kq1_ff  <= k_prod[61:30];
      cneg_ff <= {cneg_ff[2:0], cos_t[31]};
      nx2_ff  <= 51'(kq1_ff) * 51'(side_ff[IX_P1].x_mag);
      ny2_ff  <= 51'(kq1_ff) * 51'(side_ff[IX_P1].y_mag);
      u2_ff   <= 21'((v_w + BZ_HALF) >> 14);
      wx3_ff  <= 30'(({nx2_ff, 1'b0} + BX_HALF) >> 22);
      wy3_ff  <= 30'(({ny2_ff, 1'b0} + BX_HALF) >> 22);
      bq3_ff  <= bz_prod[49:32];
      u3_ff   <= u2_ff;
      qx4_ff  <= bx_prod[52:32];
      qy4_ff  <= by_prod[52:32];
      wx4_ff  <= wx3_ff;
      wy4_ff  <= wy3_ff;
      bz4_ff  <= bq3_ff + 18'(bz_rem >= 21'(D_BZ));
   end

   // result registers; flat segments give no radial field
   always_ff @(posedge clock) begin
      if (side_ff[SIDE_LEN-1].amp_zero) begin
         rsp_b_x_ff <= 24'sd0;
         rsp_b_y_ff <= 24'sd0;
      end else begin
         rsp_b_x_ff <= bx_neg ? -$signed(24'(qx)) : $signed(24'(qx));
         rsp_b_y_ff <= by_neg ? -$signed(24'(qy)) : $signed(24'(qy));
      end
      rsp_b_z_ff <= $signed(24'(bz4_ff));
      case (side_ff[SIDE_LEN-1].ez)
         EZ_CENTER: rsp_e_z_ff <= ez_center_ff;
         EZ_GAP:    rsp_e_z_ff <= ez_gap_ff;
         default:   rsp_e_z_ff <= 16'sd0;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_b_x   = rsp_b_x_ff;
   assign rsp_b_y   = rsp_b_y_ff;
   assign rsp_b_z   = rsp_b_z_ff;
   assign rsp_e_z   = rsp_e_z_ff;

`ifndef SYNTHESIS
   // fixed latency from item to result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##28 rsp_valid)
      else $error("result missing at fixed latency");

   // axial field is always positive
   a_bz_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_b_z[23] && rsp_b_z != 24'sd0))
      else $error("axial field not positive");

   // below the shaped region: no radial or electric field
   a_far_field: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_z_pos < Z_K1))
      |-> ##28 (rsp_b_x == 24'sd0 && rsp_b_y == 24'sd0 && rsp_e_z == 16'sd0))
      else $error("field outside shaped region not flat");
`endif

endmodule
`default_nettype wire

### tb/axial_field_profile_eval_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module axial_field_profile_eval_tb;
   import afpe_pkg::*;

   // register indexes of the csr channel
   localparam logic [1:0] REG_EZ_CENTER = 2'd0;
   localparam logic [1:0] REG_EZ_GAP    = 2'd1;
   localparam logic [1:0] REG_SPARE_2   = 2'd2;
   localparam logic [1:0] REG_SPARE_3   = 2'd3;

   // pipeline is 28 deep; drain allowance is taken a little wider
   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT  = 2000;

   // knot table in 1/16 mm, base and amp in tenths of a tesla
   localparam longint KNOT_Z [6] = '{-144000, -35200, -24000, 24000, 35200, 144000};
   localparam longint SEG_BASE [5] = '{6, 8, 10, 8, 6};
   localparam longint SEG_AMP  [5] = '{0, -2, 0, 2, 0};
   localparam longint ONE_Q30 = 64'sd1073741824;
   localparam longint PI_FIX  = 64'sd3373259426;

   typedef struct {
      logic signed [23:0] b_x;
      logic signed [23:0] b_y;
      logic signed [23:0] b_z;
      logic signed [15:0] e_z;
   } field_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [18:0] req_x_pos;
   logic signed [18:0] req_y_pos;
   logic signed [18:0] req_z_pos;
   logic               rsp_valid;
   logic signed [23:0] rsp_b_x;
   logic signed [23:0] rsp_b_y;
   logic signed [23:0] rsp_b_z;
   logic signed [15:0] rsp_e_z;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [15:0]        csr_wdata;

   // shadow copy of the two field registers
   logic signed [15:0] ez_center_shadow;
   logic signed [15:0] ez_gap_shadow;

   field_type expected_fields [$];
   int        fail_count;
   int        stall_count;
   int        gap_percent;

   axial_field_profile_eval dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_x_pos (req_x_pos),
      .req_y_pos (req_y_pos),
      .req_z_pos (req_z_pos),
      .rsp_valid (rsp_valid),
      .rsp_b_x   (rsp_b_x),
      .rsp_b_y   (rsp_b_y),
      .rsp_b_z   (rsp_b_z),
      .rsp_e_z   (rsp_e_z),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // q30 product, truncated toward zero
   function automatic longint mul_q30(longint a, longint b);
      longint p;
      p = a * b;
      if (p >= 0) return p >>> 30;
      return -((-p) >>> 30);
   endfunction

   // division rounded half away from zero
   function automatic longint div_round(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   // odd series through t^11, nested form
   function automatic longint sine_series(longint t);
      longint k [5];
      longint t2, s;
      k = '{110, 72, 42, 20, 6};
      t2 = mul_q30(t, t);
      s = ONE_Q30;
      for (int i = 0; i < 5; i++) s = ONE_Q30 - mul_q30(t2, s) / k[i];
      return mul_q30(t, s);
   endfunction

   // even series through t^12, nested form
   function automatic longint cosine_series(longint t);
      longint k [6];
      longint t2, c;
      k = '{132, 90, 56, 30, 12, 2};
      t2 = mul_q30(t, t);
      c = ONE_Q30;
      for (int i = 0; i < 6; i++) c = ONE_Q30 - mul_q30(t2, c) / k[i];
      return c;
   endfunction

   // field at one position under the current register settings
   function automatic field_type field_at(logic signed [18:0] xp, logic signed [18:0] yp,
                                          logic signed [18:0] zp);
      field_type f;
      longint x, y, z, amp, base, dz, t, sq, kq, bx, by, bz, ez;
      int seg;
      x = xp;
      y = yp;
      z = zp;
      seg = 0;
      // a z on an inner knot falls into the segment that starts there
      for (int i = 1; i < 5; i++)
         if (z >= KNOT_Z[i] && z < KNOT_Z[i+1]) seg = i;
      amp = SEG_AMP[seg];
      base = SEG_BASE[seg];
      dz = KNOT_Z[seg+1] - KNOT_Z[seg];
      sq = 0;
      bx = 0;
      by = 0;
      // flat segments skip the trig entirely
      if (amp != 0) begin
         t = PI_FIX * (2 * (z - KNOT_Z[seg]) - dz) / (2 * dz);
         sq = sine_series(t);
         kq = mul_q30(PI_FIX, cosine_series(t));
         bx = div_round(amp * kq * x, 64'sd16384 * 20 * dz);
         by = div_round(amp * kq * y, 64'sd16384 * 20 * dz);
      end
      bz = div_round((base * ONE_Q30 - amp * sq) * 65536, 10 * ONE_Q30);
      ez = 0;
      if (z >= -24000 && z <= 24000) ez = ez_center_shadow;
      else if (z > 24000 && z < 35200) ez = ez_gap_shadow;
      f.b_x = bx[23:0];
      f.b_y = by[23:0];
      f.b_z = bz[23:0];
      f.e_z = ez[15:0];
      return f;
   endfunction

   // one position item; returns on the edge that takes it
   task automatic send_position(int xv, int yv, int zv);
      start <= 1'b1;
      req_x_pos <= xv[18:0];
      req_y_pos <= yv[18:0];
      req_z_pos <= zv[18:0];
      do @(posedge clock); while (busy);
      expected_fields.push_back(field_at(xv[18:0], yv[18:0], zv[18:0]));
   endtask

   // each cycle idles with the current idling rate
   task automatic maybe_idle();
      while ($urandom_range(99) < gap_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic stop_sending();
      start <= 1'b0;
      @(posedge clock);
   endtask

   // every item yields a result, so an empty queue means the pipe is empty
   task automatic wait_drained();
      while (expected_fields.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_EZ_CENTER) ez_center_shadow = val;
      else if (idx == REG_EZ_GAP) ez_gap_shadow = val;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // z drawn mostly inside the table, often near a knot
   function automatic int pick_z();
      int r;
      r = $urandom_range(99);
      if (r < 25) return int'(KNOT_Z[$urandom_range(5)]) + $urandom_range(0, 6) - 3;
      if (r < 85) return $urandom_range(0, 288000) - 144000;
      return $urandom_range(0, 524287) - 262144;
   endfunction

   // positions along the axis and at the corners of the ranges
   task automatic test_directed_positions();
      int zlist [18];
      zlist = '{-262144, -144001, -144000, -35201, -35200, -24001, -24000, 0,
                24000, 24001, 35199, 35200, 35201, 143999, 144000, 262143, -30000, 30000};
      foreach (zlist[i]) send_position(0, 0, zlist[i]);
      send_position(262143, -262144, 30000);
      send_position(-262144, 262143, -30000);
      send_position(262143, 262143, 24000);
      send_position(-262144, -262144, 35200);
      send_position(-1, 1, 29600);
      stop_sending();
      wait_drained();
   endtask

   // register extremes, checked with points in both field regions
   task automatic test_ez_extremes();
      logic [15:0] vals [4];
      vals = '{16'h8000, 16'h7fff, 16'hffff, 16'h0000};
      foreach (vals[i]) begin
         write_reg(REG_EZ_CENTER, vals[i]);
         write_reg(REG_EZ_GAP, vals[(i+1)%4]);
         send_position(100, -100, 0);
         send_position(100, -100, 30000);
         send_position(100, -100, -30000);
         stop_sending();
         wait_drained();
      end
   endtask

   // writes to indexes past the last register change nothing
   task automatic test_spare_index();
      write_reg(REG_SPARE_2, 16'h1234);
      write_reg(REG_SPARE_3, 16'hfedc);
      send_position(5, 5, -5);
      send_position(5, 5, 25000);
      stop_sending();
      wait_drained();
   endtask

   task automatic test_random_positions(int count, int gap);
      gap_percent = gap;
      write_reg(REG_EZ_CENTER, 16'($urandom));
      write_reg(REG_EZ_GAP, 16'($urandom));
      for (int i = 0; i < count; i++) begin
         maybe_idle();
         send_position($urandom_range(0, 524287) - 262144,
                       $urandom_range(0, 524287) - 262144, pick_z());
      end
      stop_sending();
      wait_drained();
   endtask

   // result checker: one expectation per strobe, oldest first
   always @(posedge clock) begin
      field_type e;
      if (!reset && rsp_valid) begin
         if (expected_fields.size() == 0) begin
            $display("%0t unexpected result b_x %0d b_y %0d b_z %0d e_z %0d",
                     $time, rsp_b_x, rsp_b_y, rsp_b_z, rsp_e_z);
            fail_count++;
         end else begin
            e = expected_fields.pop_front();
            if (rsp_b_x !== e.b_x) begin
               $display("%0t b_x expected %0d actual %0d", $time, e.b_x, rsp_b_x);
               fail_count++;
            end
            if (rsp_b_y !== e.b_y) begin
               $display("%0t b_y expected %0d actual %0d", $time, e.b_y, rsp_b_y);
               fail_count++;
            end
            if (rsp_b_z !== e.b_z) begin
               $display("%0t b_z expected %0d actual %0d", $time, e.b_z, rsp_b_z);
               fail_count++;
            end
            if (rsp_e_z !== e.e_z) begin
               $display("%0t e_z expected %0d actual %0d", $time, e.e_z, rsp_e_z);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles where no item, result or register write moves
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_count <= 0;
      else if (stall_count >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else
         stall_count <= stall_count + 1;
   end

   initial begin
      fail_count = 0;
      stall_count = 0;
      gap_percent = 0;
      ez_center_shadow = 16'sd410;
      ez_gap_shadow = 16'sd1755;
      reset <= 1'b1;
      start <= 1'b0;
      req_x_pos <= '0;
      req_y_pos <= '0;
      req_z_pos <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values of the registers stay in force here
      test_directed_positions();
      test_ez_extremes();
      test_spare_index();
      test_random_positions(330, 18);
      test_random_positions(330, 59);
      test_random_positions(340, 0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_fields.size() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
`default_nettype wire
